>>> hw/rtl/lru_page_buffer_top_defines.svh
// assertion macros for the lru page buffer
// used by lru_page_buffer_top, needs a clk and rst in scope
`ifndef LRU_PAGE_BUFFER_TOP_DEFINES_SVH
`define LRU_PAGE_BUFFER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LPB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpb check failed");

// antecedent implies consequent in the next cycle
`define LPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpb check failed");

`endif

>>> hw/rtl/lpb_pkg.sv
// shared types and constants for the lru page buffer
// no dependencies
`default_nettype none

package lpb_pkg;

  localparam int OP_W    = 2;
  localparam int PAGE_W  = 16;
  localparam int OCC_W   = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_TOUCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the item and its match vector
    logic update;   // apply the item and load the result register
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [PAGE_W-1:0] evicted_page;
    logic              evicted_dirty;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/lpb_ctrl.sv
// controller for the lru page buffer: accept, update, output handshake
// depends on lpb_pkg
`default_nettype none

module lpb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output lpb_pkg::cmd_t      cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic state, state_next;
  logic out_valid, out_valid_next;
  logic slot_free;

  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = out_valid;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    cmd.capture    = 1'b0;
    cmd.update     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (slot_free) begin
          cmd.update     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lpb_datapath.sv
// datapath for the lru page buffer: entry row, tag compares, shift, result
// depends on lpb_pkg
`default_nettype none

module lpb_datapath #(
  parameter int DEPTH = 8,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lpb_pkg::cmd_t              cmd,
  input  wire logic [lpb_pkg::OP_W-1:0]   in_op,
  input  wire logic [lpb_pkg::PAGE_W-1:0] in_page,
  input  wire logic                       in_dirty,
  output lpb_pkg::result_t                result,
  output logic [CW-1:0]                   count
);

  logic [lpb_pkg::PAGE_W-1:0] entry_page [DEPTH];
  logic [DEPTH-1:0]           entry_dirty;
  logic [lpb_pkg::PAGE_W-1:0] up_page [DEPTH];
  logic [DEPTH-1:0]           up_dirty;

  logic [lpb_pkg::OP_W-1:0]   op;
  logic [lpb_pkg::PAGE_W-1:0] page;
  logic                       dirty;
  logic [DEPTH-1:0]           match;
  logic [DEPTH-1:0]           match_next;

  logic [DEPTH-1:0] ge;       // slots at or above the first match
  logic [DEPTH-1:0] first;    // one-hot first match
  logic             hit_any;
  logic             sel_dirty;
  logic             full;
  logic             do_ins;
  logic             do_touch;
  logic             do_evict;
  logic [CW-1:0]    count_m1;
  logic [CW-1:0]    count_next;

  // source for each slot when the list closes a gap toward slot 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_up
    if (g < DEPTH - 1) begin : g_mid
      assign up_page[g]  = entry_page[g+1];
      assign up_dirty[g] = entry_dirty[g+1];
    end else begin : g_top
      assign up_page[g]  = page;
      assign up_dirty[g] = dirty;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_next[i] = (CW'(i) < count) && (entry_page[i] == in_page);
    end
  end

  assign hit_any   = |match;
  assign ge        = match | (~match + DEPTH'(1));
  assign first     = ge & ~(ge << 1);
  assign sel_dirty = |(first & entry_dirty);
  assign full      = (count == CW'(DEPTH));
  assign count_m1  = count - CW'(1);
  assign do_ins    = (op == lpb_pkg::OP_INSERT);
  assign do_touch  = (op == lpb_pkg::OP_TOUCH) && hit_any;
  assign do_evict  = do_ins && full;
  assign count_next = (do_ins && !full) ? count + CW'(1) : count;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= in_op;
      page  <= in_page;
      dirty <= in_dirty;
      match <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_evict) begin
          entry_page[i]  <= up_page[i];
          entry_dirty[i] <= up_dirty[i];
        end else if (do_ins && (CW'(i) == count)) begin
          entry_page[i]  <= page;
          entry_dirty[i] <= dirty;
        end else if (do_touch && (CW'(i) == count_m1)) begin
          entry_page[i]  <= page;
          entry_dirty[i] <= sel_dirty;
        end else if (do_touch && ge[i]) begin
          entry_page[i]  <= up_page[i];
          entry_dirty[i] <= up_dirty[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.update) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.hit           <= ((op == lpb_pkg::OP_TOUCH) || (op == lpb_pkg::OP_LOOKUP))
                              && hit_any;
      result.evicted       <= do_evict;
      result.evicted_page  <= do_evict ? entry_page[0] : '0;
      result.evicted_dirty <= do_evict && entry_dirty[0];
      result.occupancy     <= lpb_pkg::OCC_W'(count_next);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lru_page_buffer_top.sv
// top level of the lru page buffer: stream ports, controller, datapath
// depends on lpb_pkg, lpb_ctrl, lpb_datapath, lru_page_buffer_top_defines.svh
//
//   channel | dir | data                                   | side
//   s_*     | in  | page, dirty                            | tuser: op
//   m_*     | out | hit, evicted, evicted_page, ev. dirty, | none
//           |     | occupancy                              |
//
// an item is handled in an accept step and an apply step: the accept edge captures
// the item together with the parallel page compares against every held entry, and
// the apply step applies the insert, eviction or move and loads the output register
// the output register lets the next item be accepted while a result waits;
// the apply step holds until that register is free
// rst clears the entry count and the handshake state, entry contents stay
// undefined until written
`default_nettype none

`include "lru_page_buffer_top_defines.svh"

module lru_page_buffer_top #(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // page[15:0], dirty[16], zero pad
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // hit[0], evicted[1], evicted_page[17:2],
                                      // evicted_dirty[18], occupancy[22:19], zero pad
);

  localparam int CW = $clog2(DEPTH + 1);

  lpb_pkg::cmd_t    cmd;
  lpb_pkg::result_t result;
  logic [CW-1:0]    count;

  lpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lpb_datapath #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_op    (s_tuser),
    .in_page  (s_tdata[15:0]),
    .in_dirty (s_tdata[16]),
    .result   (result),
    .count    (count)
  );

  // pack the result, first field in the lowest bit
  assign m_tdata = {1'b0, result.occupancy, result.evicted_dirty,
                    result.evicted_page, result.evicted, result.hit};

  // list never grows past its depth
  `LPB_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(DEPTH))
  // an accepted transfer blocks the input for the apply cycle
  `LPB_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // results only move into a free output register
  `LPB_ASSERT_SAME(a_update_slot_free, cmd.update, !m_tvalid || m_tready)

endmodule

`default_nettype wire

>>> dv/tb.sv
// self-checking testbench for lru_page_buffer_top: directed and random page traffic
// depends on lpb_pkg and the lru_page_buffer_top rtl, nothing else
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 8;
  // the op code the block leaves unused, it must pass through with no effect
  localparam logic [lpb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // one held page in the predicted lru order, slot 0 is least recent
  typedef struct packed {
    logic [lpb_pkg::PAGE_W-1:0] page;
    logic                       dirty;
  } lru_slot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // page[15:0], dirty[16], zero pad
  logic [1:0]  s_tuser = '0;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // hit[0], evicted[1], evicted_page[17:2],
                               // evicted_dirty[18], occupancy[22:19], zero pad

  // predicted page order and the results still owed by the block
  lru_slot_t          lru_list[$];
  lpb_pkg::result_t   pending_results[$];
  int unsigned        mismatches = 0;

  // idling knobs, changed per test phase
  int unsigned src_max_gap = 16;
  int unsigned sink_max_stall = 16;
  int unsigned sink_hold = 0;

  lru_page_buffer_top #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one item to the lru list and returns the result it owes
  // ---------------------------------------------------------------------------
  function automatic lpb_pkg::result_t lru_predict(logic [lpb_pkg::OP_W-1:0] op,
                                                   logic [lpb_pkg::PAGE_W-1:0] pg,
                                                   logic dm);
    lpb_pkg::result_t r;
    lru_slot_t        s;
    int               idx;
    r = '0;
    idx = -1;
    // least recent matching entry wins when a page is held more than once
    for (int i = 0; i < lru_list.size(); i++)
      if (idx < 0 && lru_list[i].page == pg) idx = i;
    case (op)
      lpb_pkg::OP_INSERT: begin
        // full list: drop the least recent entry and report it for writeback
        if (lru_list.size() >= DEPTH) begin
          s = lru_list.pop_front();
          r.evicted       = 1'b1;
          r.evicted_page  = s.page;
          r.evicted_dirty = s.dirty;
        end
        // no presence check, duplicates are legal
        lru_list.push_back({pg, dm});
      end
      lpb_pkg::OP_TOUCH: begin
        // move the found entry to the most recent end, keeping its mark
        if (idx >= 0) begin
          s = lru_list[idx];
          lru_list.delete(idx);
          lru_list.push_back(s);
          r.hit = 1'b1;
        end
      end
      lpb_pkg::OP_LOOKUP: begin
        r.hit = (idx >= 0);
      end
      default: begin
        // unused op: nothing changes, only occupancy is reported
      end
    endcase
    r.occupancy = lpb_pkg::OCC_W'(lru_list.size());
    return r;
  endfunction

  // random page biased toward held pages so touches and lookups hit often
  function automatic logic [lpb_pkg::PAGE_W-1:0] pick_page();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r < 5 && lru_list.size() > 0)
      return lru_list[$urandom_range(lru_list.size() - 1, 0)].page;
    else if (r < 7)
      return lpb_pkg::PAGE_W'($urandom_range(15, 0));
    else if (r < 8)
      return 16'hFFF0 | lpb_pkg::PAGE_W'($urandom_range(15, 0));
    return lpb_pkg::PAGE_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // source side: called and returns at a falling edge
  // valid stays high across back-to-back items, so it is never dropped and
  // raised in the same step
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [lpb_pkg::OP_W-1:0] op, logic [lpb_pkg::PAGE_W-1:0] pg,
                           logic dm);
    int unsigned gap;
    gap = $urandom_range(src_max_gap, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, dm, pg};
    s_tuser  <= op;
    // transfer happens at the rising edge with both valid and ready high
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(lru_predict(op, pg, dm));
    @(negedge clk);
  endtask

  // source goes quiet until the block has returned every owed result
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // then leave a little slack
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sink side: random stall before each result, plus an optional long hold
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    @(negedge clk);
    forever begin
      stall = sink_hold + $urandom_range(sink_max_stall, 0);
      sink_hold = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (rst || !m_tvalid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every transfer on the master side against the oldest
  // prediction, field by field
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    lpb_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual 0x%06h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("hit",           16'(want.hit),           16'(m_tdata[0]));
        check_field("evicted",       16'(want.evicted),       16'(m_tdata[1]));
        check_field("evicted_page",  want.evicted_page,       m_tdata[17:2]);
        check_field("evicted_dirty", 16'(want.evicted_dirty), 16'(m_tdata[18]));
        check_field("occupancy",     16'(want.occupancy),     16'(m_tdata[22:19]));
        check_field("pad",           16'h0,                   16'(m_tdata[23]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty list, extreme pages, duplicates, moves, misses, unused op, evictions
  task automatic test_directed();
    // empty list: nothing can hit
    send_item(lpb_pkg::OP_LOOKUP, 16'h1234, 1'b0);
    send_item(lpb_pkg::OP_TOUCH,  16'hFFFF, 1'b1);
    send_item(OP_UNUSED,          16'hFFFF, 1'b1);
    // fill to capacity, page 0 held twice
    send_item(lpb_pkg::OP_INSERT, 16'h0000, 1'b1);
    send_item(lpb_pkg::OP_INSERT, 16'hFFFF, 1'b0);
    send_item(lpb_pkg::OP_INSERT, 16'h0001, 1'b1);
    send_item(lpb_pkg::OP_INSERT, 16'h0000, 1'b0);
    send_item(lpb_pkg::OP_INSERT, 16'h8000, 1'b1);
    send_item(lpb_pkg::OP_INSERT, 16'h7FFF, 1'b0);
    send_item(lpb_pkg::OP_INSERT, 16'h00FF, 1'b1);
    send_item(lpb_pkg::OP_INSERT, 16'hFF00, 1'b0);
    // duplicates: the older copy is found and moved
    send_item(lpb_pkg::OP_LOOKUP, 16'h0000, 1'b0);
    send_item(lpb_pkg::OP_TOUCH,  16'h0000, 1'b0);
    // touching page 0 again moves its other copy, then 0xFF00 is touched
    send_item(lpb_pkg::OP_TOUCH,  16'h0000, 1'b0);
    send_item(lpb_pkg::OP_TOUCH,  16'hFF00, 1'b1);
    // absent page and unused op on a full list
    send_item(lpb_pkg::OP_LOOKUP, 16'h4242, 1'b1);
    send_item(lpb_pkg::OP_TOUCH,  16'h4242, 1'b1);
    send_item(OP_UNUSED,          16'h0000, 1'b0);
    // inserts into a full list evict both clean and dirty entries
    send_item(lpb_pkg::OP_INSERT, 16'hAAAA, 1'b1);
    send_item(lpb_pkg::OP_INSERT, 16'h5555, 1'b0);
    send_item(lpb_pkg::OP_INSERT, 16'hFFFF, 1'b1);
    send_item(lpb_pkg::OP_INSERT, 16'h0000, 1'b1);
    wait_results_drained();
  endtask

  // sink holds off for a long stretch while the source keeps pushing
  task automatic test_backpressure();
    src_max_gap = 0;
    sink_hold   = 300;
    repeat (24) send_item(lpb_pkg::OP_INSERT, pick_page(), 1'($urandom));
    wait_results_drained();
    src_max_gap = 16;
  endtask

  // mostly well-formed traffic on a small working set, some noise
  task automatic test_random_traffic(int unsigned n_items, int unsigned gap,
                                     int unsigned stall);
    int unsigned r;
    logic [lpb_pkg::OP_W-1:0] op;
    src_max_gap    = gap;
    sink_max_stall = stall;
    repeat (n_items) begin
      r = $urandom_range(99, 0);
      if (r < 40)      op = lpb_pkg::OP_INSERT;
      else if (r < 65) op = lpb_pkg::OP_TOUCH;
      else if (r < 93) op = lpb_pkg::OP_LOOKUP;
      else             op = OP_UNUSED;
      send_item(op, pick_page(), 1'($urandom));
    end
  endtask

  initial begin : main_sequence
    // synchronous reset, released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random_traffic(475, 16, 16);
    // source pauses until the block has handed back everything
    wait_results_drained();
    test_random_traffic(475, 0, 0);
    test_random_traffic(475, 16, 0);
    test_random_traffic(475, 0, 16);
    src_max_gap    = 16;
    sink_max_stall = 16;
    wait_results_drained();
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/lpb_pkg.sv
hw/rtl/lpb_ctrl.sv
hw/rtl/lpb_datapath.sv
hw/rtl/lru_page_buffer_top.sv
dv/tb.sv
